// ===== rtl/core/cvl_pkg.sv =====
// Package for the compacting value list: field widths, request kinds,
// status codes and the control word that the top level sends to every cell.
// No dependencies.
package cvl_pkg;

    localparam int CVL_DEPTH = 64;

    localparam int KIND_W    = 2;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // What every cell does in the current cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,   // the tail cell stores the value
        OP_LOAD,    // compare against the value, seed the prefix scan
        OP_SCAN,    // one doubling step of the first-match scan
        OP_SHIFT    // cells at or after the match take the next entry
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [VAL_W-1:0]   value;
    } t_cell_ctrl;

endpackage

// ===== rtl/core/cvl_cell.sv =====
// One list cell: holds one entry plus its first-match scan state.
// Depends on cvl_pkg.
module cvl_cell
    import cvl_pkg::*;
#(
    parameter int DEPTH = CVL_DEPTH,
    parameter int INDEX = 0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int STEPS = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  t_cell_ctrl                  i_ctrl,
    input  logic [CNT_W-1:0]            i_count,
    input  logic [STEPS-1:0]            i_step,
    input  logic [VAL_W-1:0]            i_next_entry,
    input  logic [STEPS-1:0]            i_left_f,
    input  logic [STEPS-1:0][IDX_W-1:0] i_left_p,
    output logic [VAL_W-1:0]            o_entry,
    output logic                        o_found,
    output logic [IDX_W-1:0]            o_pos
);

    logic [VAL_W-1:0] r_entry;
    logic             r_f;
    logic [IDX_W-1:0] r_p;
    logic             sel_f;
    logic [IDX_W-1:0] sel_p;

    // neighbor at the active doubling distance
    always_comb begin
        sel_f = 1'b0;
        sel_p = '0;
        for (int k = 0; k < STEPS; k++) begin
            if (i_step[k] && i_left_f[k]) begin
                sel_f = 1'b1;
                sel_p = i_left_p[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_WRITE: begin
                if (i_count == CNT_W'(INDEX)) begin
                    r_entry <= i_ctrl.value;
                end
            end
            OP_LOAD: begin
                r_f <= (CNT_W'(INDEX) < i_count) && (r_entry == i_ctrl.value);
                r_p <= IDX_W'(INDEX);
            end
            OP_SCAN: begin
                if (sel_f) begin
                    r_f <= 1'b1;
                    r_p <= sel_p;
                end
            end
            OP_SHIFT: begin
                if (r_f) begin
                    r_entry <= i_next_entry;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_found = r_f;
    assign o_pos   = r_p;

endmodule

// ===== rtl/core/compacting_value_list_unit.sv =====
// Top level of the compacting value list: request/result handshakes,
// sequencer and the row of cvl_cell instances. Depends on cvl_pkg, cvl_cell.
//
// A bounded list of up to DEPTH signed 32-bit values held in a row of cells,
// one entry per cell. Insert appends at the tail; remove deletes the first
// equal entry and the later cells each take their right neighbor's entry
// at once; search reports the first equal index. Every request returns
// one result (found, position, status, entry count). Insert and the unused
// kind finish without a scan; remove and search first run the first-match
// scan, a doubling prefix pass along the row, one step per cycle. A new
// request is taken as soon as the sequencer is back in idle, even while the
// previous result still sits in the output register; a finished request
// waits only for that register. Entries are not cleared at reset: only
// positions below the count are ever compared, so no clearing pass is
// needed.
module compacting_value_list_unit
    import cvl_pkg::*;
#(
    parameter int DEPTH = CVL_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [VAL_W-1:0]    i_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [POS_W-1:0]           o_position,
    output logic [STATUS_W-1:0]        o_status,
    output logic [CNT_OUT_W-1:0]       o_entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int STEPS = $clog2(DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [KIND_W-1:0]   r_kind;
    logic [VAL_W-1:0]    r_value;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STEPS-1:0]    r_step, n_step;

    logic                r_out_valid, n_out_valid;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic [STATUS_W-1:0] r_status, n_status;

    t_cell_ctrl          cell_ctrl;
    logic                in_acc;
    logic                advance;
    logic                full;
    logic                hit;

    // row wiring
    logic [VAL_W-1:0]            cell_entry [DEPTH];
    logic [DEPTH-1:0]            cell_f;
    logic [IDX_W-1:0]            cell_p     [DEPTH];
    logic [VAL_W-1:0]            next_entry [DEPTH];
    logic [STEPS-1:0]            left_f     [DEPTH];
    logic [STEPS-1:0][IDX_W-1:0] left_p     [DEPTH];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    // a result may be written when the output register is empty or drains now
    assign advance    = !r_out_valid || i_out_ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    // after the scan the last cell holds the first match of the whole row
    assign hit        = cell_f[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        r_step   <= n_step;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_step          = r_step;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_found         = r_found;
        n_pos           = r_pos;
        n_status        = r_status;
        cell_ctrl.op    = OP_HOLD;
        cell_ctrl.value = r_value;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_step = STEPS'(1);
                if (r_kind == KIND_REMOVE || r_kind == KIND_SEARCH) begin
                    cell_ctrl.op = OP_LOAD;
                    n_state      = S_SCAN;
                end else if (advance) begin
                    // insert or unused kind finishes here
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_pos       = '0;
                    n_status    = ST_DONE;
                    n_state     = S_IDLE;
                    if (r_kind == KIND_INSERT) begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cell_ctrl.op = OP_WRITE;
                            n_pos        = r_count[IDX_W-1:0];
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            S_SCAN: begin
                cell_ctrl.op = OP_SCAN;
                n_step       = r_step << 1;
                if (r_step[STEPS-1]) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    n_found     = hit;
                    n_pos       = hit ? cell_p[DEPTH-1] : '0;
                    n_status    = hit ? ST_DONE : ST_NOT_FOUND;
                    n_state     = S_IDLE;
                    if (hit && r_kind == KIND_REMOVE) begin
                        cell_ctrl.op = OP_SHIFT;
                        n_count      = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // row of cells; cell i sees cell i+1 for compaction and cell i-2^k
    // for scan step k
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_last
            assign next_entry[i] = cell_entry[i];
        end else begin : g_mid
            assign next_entry[i] = cell_entry[i+1];
        end

        for (genvar k = 0; k < STEPS; k++) begin : g_left
            if (i >= (1 << k)) begin : g_src
                assign left_f[i][k] = cell_f[i - (1 << k)];
                assign left_p[i][k] = cell_p[i - (1 << k)];
            end else begin : g_none
                assign left_f[i][k] = 1'b0;
                assign left_p[i][k] = '0;
            end
        end

        cvl_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl),
            .i_count      (r_count),
            .i_step       (r_step),
            .i_next_entry (next_entry[i]),
            .i_left_f     (left_f[i]),
            .i_left_p     (left_p[i]),
            .o_entry      (cell_entry[i]),
            .o_found      (cell_f[i]),
            .o_pos        (cell_p[i])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_position    = POS_W'(r_pos);
    assign o_status      = r_status;
    assign o_entry_count = CNT_OUT_W'(r_count);

endmodule
